FILE: sv/egwp_pkg.sv
`timescale 1ns / 1ps
package egwp_pkg;

   localparam int WORD_BITS   = 32;
   localparam int CNT_W       = $clog2(WORD_BITS + 1);
   localparam int SUM_W       = $clog2(WORD_BITS + 34);
   localparam int VALUE_W     = 16;
   localparam int N_W         = VALUE_W + 1;
   localparam int LEN_W       = $clog2(N_W + 1);
   localparam int CODE_W      = LEN_W + 1;
   localparam int PACKED_W    = 32;
   localparam int TOTAL_W     = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_FINAL  = 1'b1
   } egwp_op_type;

   // classified word handed from front to back
   typedef struct packed {
      egwp_op_type         op;
      logic [N_W-1:0]      n;
      logic [CODE_W-1:0]   code_len;
   } egwp_entry_type;

endpackage

FILE: sv/egwp_front.sv
`timescale 1ns / 1ps
module egwp_front (
   input  logic                              req_op,
   input  logic [egwp_pkg::VALUE_W-1:0]      req_value,
   output egwp_pkg::egwp_entry_type          entry
);
   import egwp_pkg::*;

   logic [N_W-1:0]   n;
   logic [LEN_W-1:0] len;

   assign n = N_W'(req_value) + N_W'(1);

   // bit length of n: highest set bit wins
   always_comb begin
      len = '0;
      for (int i = 0; i < N_W; i++) begin
         if (n[i]) begin
            len = LEN_W'(i + 1);
         end
      end
   end

   always_comb begin
      entry.op       = egwp_op_type'(req_op);
      entry.n        = n;
      entry.code_len = {len, 1'b0} - CODE_W'(1);
   end

endmodule

FILE: sv/egwp_queue.sv
`timescale 1ns / 1ps
module egwp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  egwp_pkg::egwp_entry_type  push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      not_empty,
   output egwp_pkg::egwp_entry_type  head
);
   import egwp_pkg::*;

   egwp_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count lost a push");
`endif

endmodule

FILE: sv/egwp_back.sv
`timescale 1ns / 1ps
module egwp_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  egwp_pkg::egwp_entry_type           q_head,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [egwp_pkg::PACKED_W-1:0]      rsp_packed_word,
   output logic [egwp_pkg::TOTAL_W-1:0]       rsp_total_bits,
   output logic                               rsp_overflow,
   output logic                               rsp_is_final
);
   import egwp_pkg::*;

   logic [WORD_BITS-1:0]          acc_ff, acc_in;
   logic [CNT_W-1:0]              bit_count_ff, bit_count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [PACKED_W-1:0]           packed_ff, packed_in;
   logic [TOTAL_W-1:0]            total_ff, total_in;
   logic                          overflow_ff, overflow_in;
   logic                          is_final_ff, is_final_in;

   logic [WORD_BITS-1:0]          rev;
   logic [WORD_BITS-1:0]          emitted;
   logic [WORD_BITS+PACKED_W-1:0] emitted_ext;
   logic [WORD_BITS+N_W-1:0]      n_ext;
   logic [SUM_W-1:0]              sum;
   logic                          fits;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         rev[i] = acc_ff[WORD_BITS-1-i];
      end
   end

   // reversed word sits high; bring the held bits down to the lsb
   assign emitted     = rev >> (CNT_W'(WORD_BITS) - bit_count_ff);
   assign emitted_ext = (WORD_BITS + PACKED_W)'(emitted);
   assign n_ext       = (WORD_BITS + N_W)'(q_head.n);
   assign sum         = SUM_W'(bit_count_ff) + SUM_W'(q_head.code_len);
   assign fits        = (sum <= SUM_W'(WORD_BITS));

   always_comb begin
      acc_in       = acc_ff;
      bit_count_in = bit_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      packed_in    = packed_ff;
      total_in     = total_ff;
      overflow_in  = overflow_ff;
      is_final_in  = is_final_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
         if (q_head.op == OP_FINAL) begin
            packed_in    = emitted_ext[PACKED_W-1:0];
            total_in     = TOTAL_W'(bit_count_ff);
            overflow_in  = 1'b0;
            is_final_in  = 1'b1;
            acc_in       = '0;
            bit_count_in = '0;
         end else begin
            packed_in   = '0;
            is_final_in = 1'b0;
            overflow_in = !fits;
            if (fits) begin
               acc_in       = (acc_ff << q_head.code_len) | n_ext[WORD_BITS-1:0];
               bit_count_in = CNT_W'(sum);
               total_in     = TOTAL_W'(sum);
            end else begin
               total_in = TOTAL_W'(bit_count_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         bit_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         bit_count_ff <= bit_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      packed_ff   <= packed_in;
      total_ff    <= total_in;
      overflow_ff <= overflow_in;
      is_final_ff <= is_final_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_word = packed_ff;
   assign rsp_total_bits  = total_ff;
   assign rsp_overflow    = overflow_ff;
   assign rsp_is_final    = is_final_ff;

`ifndef SYNTHESIS
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.op == OP_FINAL) |=> (bit_count_ff == '0 && acc_ff == '0))
      else $error("finalize left state behind");
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.op == OP_APPEND && !fits) |=> ($stable(acc_ff) && $stable(bit_count_ff)))
      else $error("rejected append changed state");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (bit_count_ff <= CNT_W'(WORD_BITS)))
      else $error("bit count beyond word");
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(overflow_ff && is_final_ff))
      else $error("overflow flagged on finalize");
`endif

endmodule

FILE: sv/exp_golomb_word_packer.sv
`timescale 1ns / 1ps
// order-0 exp-golomb packer: builds one word from a run of append words
// and hands it out, bit-reversed, on a finalize word.
// req channel: req_op (append or finalize) and req_value, valid/ready.
// rsp channel: one result word per request: rsp_packed_word, rsp_total_bits,
//   rsp_overflow, rsp_is_final, valid/ready.
// path: an accepted request is written into the queue, then popped into the
//   result register when nothing is waiting.
// throughput: one word per cycle while the receiver keeps rsp_ready high; the
//   accumulator update in the back end (shift plus bit-length add and compare) is the loop through acc_ff.
// a two-entry queue sits between classification and the accumulator, so
//   req_ready depends only on queue occupancy, never on rsp_ready.
// when the receiver stalls the result register holds, the queue fills and
//   req_ready drops after two more words.
// reset (synchronous, active high) clears accumulator, bit count, queue and
//   the output valid; the block takes requests from the next cycle on.
// an append that does not fit leaves the word untouched and flags overflow.
module exp_golomb_word_packer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [egwp_pkg::VALUE_W-1:0]       req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [egwp_pkg::PACKED_W-1:0]      rsp_packed_word,
   output logic [egwp_pkg::TOTAL_W-1:0]       rsp_total_bits,
   output logic                               rsp_overflow,
   output logic                               rsp_is_final
);
   import egwp_pkg::*;

   egwp_entry_type front_entry;
   egwp_entry_type q_head;
   logic           q_full;
   logic           q_valid;
   logic           q_pop;
   logic           push;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   egwp_front u_front (
      .req_op    (req_op),
      .req_value (req_value),
      .entry     (front_entry)
   );

   egwp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   egwp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packed_word (rsp_packed_word),
      .rsp_total_bits  (rsp_total_bits),
      .rsp_overflow    (rsp_overflow),
      .rsp_is_final    (rsp_is_final)
   );

endmodule
